/* rtl/core/b64u_pkg.sv */
// Shared types, phase codes and the base64url alphabet for the encoder.
package b64u_pkg;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       out_last;
  } out_item_t;

  // Position of the next byte within its group of three.
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  localparam logic [6:0] ASCII_UPPER_A = 7'h41;
  localparam logic [6:0] ASCII_LOWER_A = 7'h61;
  localparam logic [6:0] ASCII_ZERO    = 7'h30;
  localparam logic [6:0] ASCII_DASH    = 7'h2D;
  localparam logic [6:0] ASCII_UNDER   = 7'h5F;

  localparam logic [5:0] IDX_LOWER = 6'd26;
  localparam logic [5:0] IDX_DIGIT = 6'd52;
  localparam logic [5:0] IDX_DASH  = 6'd62;

  // Maps a 6-bit sextet to its base64url ASCII code.
  function automatic logic [6:0] b64u_char(input logic [5:0] idx);
    logic [6:0] res;
    if (idx < IDX_LOWER) begin
      res = ASCII_UPPER_A + {1'b0, idx};
    end else if (idx < IDX_DIGIT) begin
      res = ASCII_LOWER_A + {1'b0, idx - IDX_LOWER};
    end else if (idx < IDX_DASH) begin
      res = ASCII_ZERO + {1'b0, idx - IDX_DIGIT};
    end else if (idx == IDX_DASH) begin
      res = ASCII_DASH;
    end else begin
      res = ASCII_UNDER;
    end
    return res;
  endfunction

endpackage

/* rtl/core/base64url_encoder.sv */
// Streaming base64url encoder without padding, one byte in and one character out per transfer.
//
// Usage:
//   The input channel (in_valid/in_ready/in_data) takes one raw byte per
//   transfer together with a flag that marks the last byte of a message.
//   The output channel (out_valid/out_ready/out_data) gives one ASCII
//   character per transfer; the final character of a message has out_last set.
//   A byte yields one or two characters. They are written into a four-entry
//   character queue in the cycle the byte is taken, and are offered from the
//   registered queue behind any characters already waiting.
//   Throughput is set by the output port, which drains one character per
//   cycle while out_ready is high: three bytes give four characters, and a
//   byte that closes a group or a message gives two. in_ready is high while
//   the queue has room for two characters, so bytes keep flowing while
//   results wait. When the receiver stalls the queue fills and in_ready falls;
//   nothing is dropped. Reset empties the queue and returns the group phase
//   and the kept bits to zero, ready for the first byte of a new message.
module base64url_encoder
  import b64u_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned PW     = $clog2(QDEPTH);

  out_item_t       queue_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]     count_r, count_nxt;
  logic [1:0]      byte_phase_r, byte_phase_nxt;
  logic [5:0]      pending_bits_r, pending_bits_nxt;

  logic            push, pop, two;
  logic [5:0]      idx0, idx1, keep;
  logic            last1;
  logic [1:0]      phase_after;
  logic [PW-1:0]   wr_ptr_inc;

  assign in_ready  = count_r <= (PW+1)'(QDEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_data  = queue_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    idx0        = '0;
    idx1        = '0;
    keep        = '0;
    last1       = in_data.last_byte;
    two         = in_data.last_byte;
    phase_after = PH_FIRST;
    case (byte_phase_r)
      PH_SECOND: begin
        idx0        = pending_bits_r | {2'b00, in_data.raw_byte[7:4]};
        keep        = {in_data.raw_byte[3:0], 2'b00};
        idx1        = keep;
        phase_after = PH_THIRD;
      end
      PH_THIRD: begin
        idx0        = pending_bits_r | {4'b0000, in_data.raw_byte[7:6]};
        idx1        = in_data.raw_byte[5:0];
        keep        = '0;
        two         = 1'b1;
        phase_after = PH_FIRST;
      end
      default: begin
        idx0        = in_data.raw_byte[7:2];
        keep        = {in_data.raw_byte[1:0], 4'b0000};
        idx1        = keep;
        phase_after = PH_SECOND;
      end
    endcase
  end

  assign wr_ptr_inc = wr_ptr_r + PW'(1);

  always_comb begin
    byte_phase_nxt   = byte_phase_r;
    pending_bits_nxt = pending_bits_r;
    wr_ptr_nxt       = wr_ptr_r;
    rd_ptr_nxt       = rd_ptr_r;
    count_nxt        = count_r;
    if (push) begin
      // A last byte always ends the message, so the group state starts over.
      byte_phase_nxt   = in_data.last_byte ? PH_FIRST : phase_after;
      pending_bits_nxt = in_data.last_byte ? '0 : keep;
      wr_ptr_nxt       = two ? wr_ptr_r + PW'(2) : wr_ptr_inc;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + (push ? (two ? (PW+1)'(2) : (PW+1)'(1)) : '0)
                        - (pop ? (PW+1)'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_phase_r   <= PH_FIRST;
      pending_bits_r <= '0;
      wr_ptr_r       <= '0;
      rd_ptr_r       <= '0;
      count_r        <= '0;
    end else begin
      byte_phase_r   <= byte_phase_nxt;
      pending_bits_r <= pending_bits_nxt;
      wr_ptr_r       <= wr_ptr_nxt;
      rd_ptr_r       <= rd_ptr_nxt;
      count_r        <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= '{out_char: b64u_char(idx0), out_last: 1'b0};
      if (two) begin
        queue_r[wr_ptr_inc] <= '{out_char: b64u_char(idx1), out_last: last1};
      end
    end
  end

endmodule

/* test/b64u_checker.sv */
// Scoreboard for the base64url encoder: predicts characters from input transfers and checks output.
module b64u_checker
  import b64u_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_data,
  output int unsigned      fail_count,
  output int unsigned      pending_count
);

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  logic [1:0]  group_phase = PH_FIRST;
  logic [5:0]  kept_bits = '0;
  out_item_t   expected_chars [$];
  out_item_t   want;
  int unsigned mismatches = 0;

  // The alphabet string is packed with its first character in the top byte.
  function automatic logic [6:0] sextet_to_ascii(input logic [5:0] idx);
    int pos;
    pos = 8 * (63 - int'(idx));
    return ALPHABET[pos +: 7];
  endfunction

  task automatic queue_char(input logic [5:0] idx, input logic last);
    out_item_t c;
    c.out_char = sextet_to_ascii(idx);
    c.out_last = last;
    expected_chars.push_back(c);
  endtask

  task automatic encode_byte(input in_item_t item);
    logic [7:0] b;
    b = item.raw_byte;
    case (group_phase)
      PH_SECOND: begin
        queue_char(kept_bits | {2'b00, b[7:4]}, 1'b0);
        kept_bits   = {b[3:0], 2'b00};
        group_phase = PH_THIRD;
        if (item.last_byte) begin
          queue_char(kept_bits, 1'b1);
        end
      end
      PH_THIRD: begin
        queue_char(kept_bits | {4'b0000, b[7:6]}, 1'b0);
        queue_char(b[5:0], item.last_byte);
        kept_bits   = '0;
        group_phase = PH_FIRST;
      end
      default: begin
        queue_char(b[7:2], 1'b0);
        kept_bits   = {b[1:0], 4'b0000};
        group_phase = PH_SECOND;
        if (item.last_byte) begin
          queue_char(kept_bits, 1'b1);
        end
      end
    endcase
    // A finished message starts the next one from a clean group.
    if (item.last_byte) begin
      group_phase = PH_FIRST;
      kept_bits   = '0;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("b64u_checker: mismatch: %s", what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      group_phase = PH_FIRST;
      kept_bits   = '0;
      expected_chars.delete();
    end else begin
      // Check the output first: a character leaving now always belongs to an earlier byte.
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h last %0b with nothing expected",
                                    out_data.out_char, out_data.out_last));
        end else begin
          want = expected_chars.pop_front();
          if (out_data.out_char !== want.out_char) begin
            report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                      out_data.out_char, want.out_char));
          end
          if (out_data.out_last !== want.out_last) begin
            report_mismatch($sformatf("out_last %0b, expected %0b on char 0x%02h",
                                      out_data.out_last, want.out_last, want.out_char));
          end
        end
      end
      if (in_valid && in_ready) begin
        encode_byte(in_data);
      end
    end
    pending_count <= expected_chars.size();
    fail_count    <= mismatches;
  end

endmodule

/* test/tb_top.sv */
// Testbench top for the base64url encoder: clock, reset, traffic on both channels and the verdict.
module tb_top;
  import b64u_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1880;
  localparam int unsigned CALM_TAIL    = 250;
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int unsigned HOLD_CYCLES  = 160;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned N_OPENING    = 18;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned items_sent = 0;
  int unsigned idle_odds = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  logic        hold_off = 1'b0;

  base64url_encoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  b64u_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus the long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Holds the receiver off long enough for the character queue to fill and stall the input.
  initial begin
    wait (items_sent >= HOLD_AFTER);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_byte(input logic [7:0] data, input logic last);
    int unsigned gap;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{raw_byte: data, last_byte: last};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  initial begin
    logic [8:0] opening [N_OPENING];
    int unsigned total;
    int unsigned len;

    // Each entry is {raw_byte, last_byte}. Messages end in every group phase,
    // and the groups FB EF BE and FF FF FF hit the two punctuation characters.
    opening = '{
      {8'h00, 1'b1},
      {8'hFF, 1'b1},
      {8'hFF, 1'b0}, {8'hFF, 1'b1},
      {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b1},
      {8'hFB, 1'b0}, {8'hEF, 1'b0}, {8'hBE, 1'b0},
      {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0},
      {8'hA5, 1'b1},
      {8'h4D, 1'b0}, {8'h61, 1'b0}, {8'h6E, 1'b0}, {8'h80, 1'b1}
    };
    total = N_OPENING + RANDOM_ITEMS;
    wait (rst_n);
    @(posedge clk);

    for (int unsigned i = 0; i < N_OPENING; i++) begin
      send_byte(opening[i][8:1], opening[i][0]);
    end

    idle_odds = 4;
    while (items_sent < total) begin
      if (items_sent + CALM_TAIL >= total) begin
        idle_odds = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_odds = 0;
          1:       idle_odds = 2;
          default: idle_odds = 6;
        endcase
      end
      if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(11, 40);
      end else begin
        len = $urandom_range(1, 10);
      end
      send_message(len);
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
